// ----- hdl/lrd_pkg.sv -----
// Shared types, codes and the CRC-32 byte update for the log record deframer.
// Depends on nothing; the top level, front, queue and back modules import it.
package lrd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // byte_kind codes
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_KEY   = 2'd1;
  localparam logic [1:0] KIND_VALUE = 2'd2;

  // record_status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_TRUNC    = 2'd2;

  typedef enum logic [5:0] {
    PH_CRC  = 6'b000001,
    PH_OP   = 6'b000010,
    PH_KLEN = 6'b000100,
    PH_VLEN = 6'b001000,
    PH_KEY  = 6'b010000,
    PH_VAL  = 6'b100000
  } phase_e;

  // One queued step of work for the back end
  typedef struct packed {
    logic        crc_init;  // restart the running CRC at all ones
    logic        crc_feed;  // fold data into the running CRC
    logic        emit;      // step yields a result
    logic        rec_end;   // result closes a record
    logic        trunc;     // record cut short by end of log
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  op;
    logic [31:0] klen;
    logic [31:0] vlen;
    logic [31:0] scrc;
  } entry_t;

  // Reflected CRC-32 over one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ----- hdl/lrd_in_if.sv -----
// Input byte channel of the log record deframer.
// Depends on nothing.
interface lrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] log_byte;
  logic       end_of_log;

  modport source (output valid, output log_byte, output end_of_log, input ready);
  modport sink   (input valid, input log_byte, input end_of_log, output ready);
endinterface

// ----- hdl/lrd_out_if.sv -----
// Result channel of the log record deframer.
// Depends on nothing.
interface lrd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_kind;
  logic [7:0]  payload_byte;
  logic        record_end;
  logic [1:0]  record_status;
  logic [7:0]  record_op;
  logic [31:0] key_length;
  logic [31:0] value_length;

  modport source (output valid, output byte_kind, output payload_byte, output record_end,
                  output record_status, output record_op, output key_length,
                  output value_length, input ready);
  modport sink   (input valid, input byte_kind, input payload_byte, input record_end,
                  input record_status, input record_op, input key_length,
                  input value_length, output ready);
endinterface

// ----- hdl/log_record_deframer_crc32_core.sv -----
// Log record deframer with CRC-32 check, top level.
// Takes one byte per cycle while the queue has space; a result is queued, then registered.
// Sustained rate one byte per cycle while the output is ready, with a byte-wide CRC update.
// A two-entry queue parts the framing front end from the CRC and result back end.
// Asynchronous active-low reset returns to the start of a record, CRC at all ones.
// Depends on lrd_pkg, lrd_in_if, lrd_out_if, lrd_front, lrd_queue and lrd_back.
module log_record_deframer_crc32_core import lrd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lrd_in_if.sink    in_i,
  lrd_out_if.source out_o
);

  logic   push;
  logic   space;
  logic   pop;
  logic   head_valid;
  entry_t entry;
  entry_t head;

  lrd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .space_i (space),
    .push_o  (push),
    .entry_o (entry)
  );

  lrd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .space_o      (space),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  lrd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ----- hdl/lrd_front.sv -----
// Front end: accepts log bytes, tracks the record framing and queues work steps.
// Depends on lrd_pkg and lrd_in_if.
module lrd_front import lrd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  lrd_in_if.sink in_i,
  input  logic   space_i,
  output logic   push_o,
  output entry_t entry_o
);

  phase_e      phase_q, phase_d;
  logic [1:0]  idx_q, idx_d;
  logic [31:0] scrc_q, scrc_d;
  logic [7:0]  op_q, op_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic [31:0] rem_q, rem_d;

  logic        acc;
  logic [31:0] lane;
  logic [31:0] rem_m1;
  logic        last_idx;

  assign in_i.ready = space_i;
  assign acc        = in_i.valid & space_i;
  assign lane       = {24'd0, in_i.log_byte} << {idx_q, 3'b000};
  assign rem_m1     = rem_q - 32'd1;
  assign last_idx   = (idx_q == 2'd3);

  // Classify the beat and work out the next framing state
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    scrc_d  = scrc_q;
    op_d    = op_q;
    klen_d  = klen_q;
    vlen_d  = vlen_q;
    rem_d   = rem_q;
    push_o  = 1'b0;
    entry_o = '0;
    entry_o.data = in_i.log_byte;

    if (acc) begin
      if (in_i.end_of_log) begin
        if (!(phase_q == PH_CRC && idx_q == 2'd0)) begin
          push_o          = 1'b1;
          entry_o.emit    = 1'b1;
          entry_o.rec_end = 1'b1;
          entry_o.trunc   = 1'b1;
          entry_o.kind    = KIND_NONE;
          phase_d         = PH_CRC;
          idx_d           = 2'd0;
          rem_d           = '0;
        end
      end else begin
        unique case (phase_q)
          PH_OP: begin
            op_d             = in_i.log_byte;
            push_o           = 1'b1;
            entry_o.crc_feed = 1'b1;
            phase_d          = PH_KLEN;
            idx_d            = 2'd0;
          end
          PH_KLEN: begin
            klen_d           = klen_q | lane;
            push_o           = 1'b1;
            entry_o.crc_feed = 1'b1;
            idx_d            = idx_q + 2'd1;
            if (last_idx) phase_d = PH_VLEN;
          end
          PH_VLEN: begin
            vlen_d           = vlen_q | lane;
            push_o           = 1'b1;
            entry_o.crc_feed = 1'b1;
            idx_d            = idx_q + 2'd1;
            if (last_idx) begin
              if (klen_q != '0) begin
                phase_d = PH_KEY;
                rem_d   = klen_q;
              end else if (vlen_d != '0) begin
                phase_d = PH_VAL;
                rem_d   = vlen_d;
              end else begin
                entry_o.emit    = 1'b1;
                entry_o.rec_end = 1'b1;
                entry_o.kind    = KIND_NONE;
                phase_d         = PH_CRC;
                rem_d           = '0;
              end
            end
          end
          PH_KEY: begin
            push_o           = 1'b1;
            entry_o.crc_feed = 1'b1;
            entry_o.emit     = 1'b1;
            entry_o.kind     = KIND_KEY;
            if (rem_m1 != '0) begin
              rem_d = rem_m1;
            end else if (vlen_q != '0) begin
              phase_d = PH_VAL;
              rem_d   = vlen_q;
            end else begin
              entry_o.rec_end = 1'b1;
              phase_d         = PH_CRC;
              idx_d           = 2'd0;
              rem_d           = '0;
            end
          end
          PH_VAL: begin
            push_o           = 1'b1;
            entry_o.crc_feed = 1'b1;
            entry_o.emit     = 1'b1;
            entry_o.kind     = KIND_VALUE;
            if (rem_m1 != '0) begin
              rem_d = rem_m1;
            end else begin
              entry_o.rec_end = 1'b1;
              phase_d         = PH_CRC;
              idx_d           = 2'd0;
              rem_d           = '0;
            end
          end
          default: begin
            // Stored CRC field; the first byte opens a new record
            if (idx_q == 2'd0) begin
              scrc_d           = lane;
              op_d             = '0;
              klen_d           = '0;
              vlen_d           = '0;
              push_o           = 1'b1;
              entry_o.crc_init = 1'b1;
            end else begin
              scrc_d = scrc_q | lane;
            end
            idx_d = idx_q + 2'd1;
            if (last_idx) phase_d = PH_OP;
            else          phase_d = PH_CRC;
          end
        endcase
      end
    end

    entry_o.op   = op_d;
    entry_o.klen = klen_d;
    entry_o.vlen = vlen_d;
    entry_o.scrc = scrc_d;
  end

  // Hold the framing state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CRC;
      idx_q   <= '0;
      scrc_q  <= '0;
      op_q    <= '0;
      klen_q  <= '0;
      vlen_q  <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      scrc_q  <= scrc_d;
      op_q    <= op_d;
      klen_q  <= klen_d;
      vlen_q  <= vlen_d;
      rem_q   <= rem_d;
    end
  end

endmodule

// ----- hdl/lrd_queue.sv -----
// Two-entry queue of work steps between the front and back ends.
// Depends on lrd_pkg.
module lrd_queue import lrd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   space_o,
  input  logic   pop_i,
  output logic   head_valid_o,
  output entry_t head_o
);

  entry_t     slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign space_o      = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i & space_o;
  assign do_pop       = pop_i & head_valid_o;

  // Store the incoming step
  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_ptr_q] <= entry_i;
  end

  // Advance the pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- hdl/lrd_back.sv -----
// Back end: runs the CRC-32, checks it at record end and registers the results.
// Depends on lrd_pkg and lrd_out_if.
module lrd_back import lrd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  entry_t     head_i,
  output logic       pop_o,
  lrd_out_if.source  out_o
);

  logic [31:0] crc_q;
  logic [31:0] crc_upd;
  logic        valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  byte_q;
  logic        end_q;
  logic [1:0]  stat_q;
  logic [7:0]  op_q;
  logic [31:0] klen_q;
  logic [31:0] vlen_q;
  logic [1:0]  stat;
  logic        load;

  assign crc_upd = crc_byte(crc_q, head_i.data);
  assign pop_o   = head_valid_i & (~head_i.emit | ~valid_q | out_o.ready);
  assign load    = pop_o & head_i.emit;

  // Pick the record status
  always_comb begin
    if (head_i.trunc) begin
      stat = STAT_TRUNC;
    end else if (head_i.rec_end) begin
      stat = ((crc_upd ^ CRC_ONES) == head_i.scrc) ? STAT_OK : STAT_MISMATCH;
    end else begin
      stat = STAT_OK;
    end
  end

  // Advance the running CRC and the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_ONES;
      valid_q <= 1'b0;
    end else begin
      if (pop_o && head_i.crc_init)      crc_q <= CRC_ONES;
      else if (pop_o && head_i.crc_feed) crc_q <= crc_upd;
      if (load)              valid_q <= 1'b1;
      else if (out_o.ready)  valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= head_i.kind;
      byte_q <= (head_i.kind == KIND_NONE) ? 8'd0 : head_i.data;
      end_q  <= head_i.rec_end;
      stat_q <= stat;
      op_q   <= head_i.op;
      klen_q <= head_i.klen;
      vlen_q <= head_i.vlen;
    end
  end

  assign out_o.valid         = valid_q;
  assign out_o.byte_kind     = kind_q;
  assign out_o.payload_byte  = byte_q;
  assign out_o.record_end    = end_q;
  assign out_o.record_status = stat_q;
  assign out_o.record_op     = op_q;
  assign out_o.key_length    = klen_q;
  assign out_o.value_length  = vlen_q;

endmodule
